// ===== rtl/view_projection_rotate_scale_macros.svh =====
// assertion macros for the view projection block
`ifndef VIEW_PROJECTION_ROTATE_SCALE_MACROS_SVH
`define VIEW_PROJECTION_ROTATE_SCALE_MACROS_SVH

`ifndef SYNTH
`define VPRS_ASSERT_IMP(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("vprs assertion failed");
`define VPRS_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("vprs assertion failed");
`define VPRS_ASSERT_DELAY(lbl, ante, n, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> ##n (cons)) \
    else $error("vprs assertion failed");
`else
`define VPRS_ASSERT_IMP(lbl, ante, cons)
`define VPRS_ASSERT_NEXT(lbl, ante, cons)
`define VPRS_ASSERT_DELAY(lbl, ante, n, cons)
`endif

`endif

// ===== rtl/vprs_pkg.sv =====
// shared types, constants and tables of the view projection block
package vprs_pkg;

  localparam int ROTATE_STAGES = 16;
  localparam int DIV_STEPS     = 32;
  localparam int CW            = 60;
  localparam int MW            = CW / 2;
  localparam int ZW            = 34;

  localparam logic [MW-1:0] GAIN_INV_Q30 = 30'h26DD3B6A;

  localparam int CFG_IDX_W = 3;
  localparam logic [CFG_IDX_W-1:0] CFG_ORIGIN_X    = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_ORIGIN_Y    = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_VIEW_YAW    = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_VIEW_EXTENT = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_ROTATE      = 3'd4;

  localparam logic OP_TO_FRAME = 1'b0;
  localparam logic OP_TO_WORLD = 1'b1;

  localparam logic [31:0] ATAN_TAB [32] = '{
    32'h20000000, 32'h12E4051E, 32'h09FB385B, 32'h051111D4, 32'h028B0D43, 32'h0145D7E1,
    32'h00A2F61E, 32'h00517C55, 32'h0028BE53, 32'h00145F2F, 32'h000A2F98, 32'h000517CC,
    32'h00028BE6, 32'h000145F3, 32'h0000A2FA, 32'h0000517D, 32'h000028BE, 32'h0000145F,
    32'h00000A30, 32'h00000518, 32'h0000028C, 32'h00000146, 32'h000000A3, 32'h00000051,
    32'h00000029, 32'h00000014, 32'h0000000A, 32'h00000005, 32'h00000003, 32'h00000001,
    32'h00000001, 32'h00000000
  };

  typedef struct packed {
    logic               op;
    logic signed [31:0] coord_a;
    logic signed [31:0] coord_b;
  } in_item_t;

  typedef struct packed {
    logic signed [31:0] out_a;
    logic signed [31:0] out_b;
    logic               clipped;
  } out_item_t;

  typedef struct packed {
    logic vld;
    logic op;
    logic div_en;
  } ctl_t;

  typedef struct packed {
    logic signed [CW-1:0] x;
    logic signed [CW-1:0] y;
    logic signed [ZW-1:0] z;
  } cord_t;

  typedef struct packed {
    logic [31:0] rem;
    logic [31:0] num;
    logic [31:0] q;
    logic        neg;
    logic        ovf;
  } div_lane_t;

endpackage

// ===== rtl/view_projection_rotate_scale.sv =====
// top level: world/frame coordinate transform with rotation and scaling
//
//  channel   ports                          transfer
//  input     start, busy, in_data           start high and busy low at a rising edge
//  result    out_strobe, out_data           one cycle with out_strobe high
//  config    cfg_we, cfg_idx, cfg_wdata     cfg_we high at a rising edge
//
// one point enters every cycle; busy is always low
// pipeline registers: front end (3), rotation cells, gain
// correction (2), divider setup (3), 32 divider cells, output register
// synchronous active-low reset clears all valid flags and loads register defaults
// the receiver cannot stall, so results leave the chain without back pressure
`include "view_projection_rotate_scale_macros.svh"
module view_projection_rotate_scale import vprs_pkg::*; (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 start,
  output logic                 busy,
  input  in_item_t             in_data,
  output logic                 out_strobe,
  output out_item_t            out_data,
  input  logic                 cfg_we,
  input  logic [CFG_IDX_W-1:0] cfg_idx,
  input  logic [31:0]          cfg_wdata
);

  localparam int LAT = ROTATE_STAGES + DIV_STEPS + 9;
  localparam int RW  = CW - 6;
  localparam int SW  = 56;
  localparam logic [2*MW:0] RND_HALF = (2*MW+1)'(1) << (MW - 1);

  // configuration
  logic signed [31:0] origin_x_r;
  logic signed [31:0] origin_y_r;
  logic [15:0]        view_yaw_r;
  logic [31:0]        view_extent_r;
  logic               rotate_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      origin_x_r    <= '0;
      origin_y_r    <= '0;
      view_yaw_r    <= '0;
      view_extent_r <= 32'd256;
      rotate_r      <= 1'b0;
    end else if (cfg_we) begin
      unique case (cfg_idx)
        CFG_ORIGIN_X:    origin_x_r    <= cfg_wdata;
        CFG_ORIGIN_Y:    origin_y_r    <= cfg_wdata;
        CFG_VIEW_YAW:    view_yaw_r    <= cfg_wdata[15:0];
        CFG_VIEW_EXTENT: view_extent_r <= cfg_wdata;
        CFG_ROTATE:      rotate_r      <= cfg_wdata[0];
        default: ;
      endcase
    end
  end

  logic in_acc;
  assign busy   = 1'b0;
  assign in_acc = start & ~busy;

  // stage a: input register
  logic               a_vld_r;
  logic               a_op_r;
  logic signed [31:0] a_ca_r;
  logic signed [31:0] a_cb_r;

  // stage b: products and origin differences
  logic               b_vld_r;
  logic               b_op_r;
  logic signed [63:0] b_pa_r;
  logic signed [63:0] b_pb_r;
  logic signed [32:0] b_da_r;
  logic signed [32:0] b_db_r;
  logic signed [64:0] pa_full;
  logic signed [64:0] pb_full;
  logic signed [32:0] da;
  logic signed [32:0] db;

  assign pa_full = $signed(a_ca_r) * $signed({1'b0, view_extent_r});
  assign pb_full = $signed(a_cb_r) * $signed({1'b0, view_extent_r});
  assign da      = $signed({a_ca_r[31], a_ca_r}) - $signed({origin_x_r[31], origin_x_r});
  assign db      = $signed({a_cb_r[31], a_cb_r}) - $signed({origin_y_r[31], origin_y_r});

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      a_vld_r <= 1'b0;
      b_vld_r <= 1'b0;
    end else begin
      a_vld_r <= in_acc;
      b_vld_r <= a_vld_r;
    end
  end

  always_ff @(posedge clk) begin
    a_op_r <= in_data.op;
    a_ca_r <= in_data.coord_a;
    a_cb_r <= in_data.coord_b;
    b_op_r <= a_op_r;
    b_pa_r <= pa_full[63:0];
    b_pb_r <= pb_full[63:0];
    b_da_r <= da;
    b_db_r <= db;
  end

  // stage c: operand select, half turn for the back quadrants
  ctl_t                 c_ctl_r;
  cord_t                c_cord_r;
  cord_t                c_cord_nxt;
  logic signed [63:0]   nb;
  logic signed [63:0]   nb_sh;
  logic signed [63:0]   pa_sh;
  logic signed [CW-1:0] x0;
  logic signed [CW-1:0] y0;
  logic [15:0]          yaw_neg;
  logic [31:0]          ang;
  logic [31:0]          ang_adj;
  logic                 flip;

  always_comb begin
    nb      = -b_pb_r;
    nb_sh   = nb >>> 8;
    pa_sh   = b_pa_r >>> 8;
    yaw_neg = 16'd0 - view_yaw_r;
    if (b_op_r == OP_TO_WORLD) begin
      x0  = nb_sh[CW-1:0];
      y0  = pa_sh[CW-1:0];
      ang = {view_yaw_r, 16'd0};
    end else begin
      x0  = {{(CW-49){b_da_r[32]}}, b_da_r, 16'd0};
      y0  = {{(CW-49){b_db_r[32]}}, b_db_r, 16'd0};
      ang = {yaw_neg, 16'd0};
    end
    flip         = rotate_r & (ang[31] ^ ang[30]);
    ang_adj      = {ang[31] ^ flip, ang[30:0]};
    c_cord_nxt.x = flip ? -x0 : x0;
    c_cord_nxt.y = flip ? -y0 : y0;
    c_cord_nxt.z = {{(ZW-32){ang_adj[31]}}, ang_adj};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      c_ctl_r <= '0;
    end else begin
      c_ctl_r.vld    <= b_vld_r;
      c_ctl_r.op     <= b_op_r;
      c_ctl_r.div_en <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    c_cord_r <= c_cord_nxt;
  end

  // rotation cell chain
  ctl_t  cc_ctl  [ROTATE_STAGES+1];
  cord_t cc_cord [ROTATE_STAGES+1];

  assign cc_ctl[0]  = c_ctl_r;
  assign cc_cord[0] = c_cord_r;

  for (genvar i = 0; i < ROTATE_STAGES; i++) begin : g_rot
    vprs_cordic_cell u_cell (
      .clk      (clk),
      .rst_n    (rst_n),
      .stage_idx(5'(i)),
      .rot_en   (rotate_r),
      .ctl_in   (cc_ctl[i]),
      .cord_in  (cc_cord[i]),
      .ctl_out  (cc_ctl[i+1]),
      .cord_out (cc_cord[i+1])
    );
  end

  // gain correction, split multiply
  ctl_t                 g1_ctl_r;
  logic                 g1_negx_r;
  logic                 g1_negy_r;
  logic [2*MW-1:0]      g1_plox_r;
  logic [2*MW-1:0]      g1_phix_r;
  logic [2*MW-1:0]      g1_ploy_r;
  logic [2*MW-1:0]      g1_phiy_r;
  logic signed [CW-1:0] g1_x_r;
  logic signed [CW-1:0] g1_y_r;
  logic signed [CW-1:0] rx_in;
  logic signed [CW-1:0] ry_in;
  logic [CW-1:0]        magx;
  logic [CW-1:0]        magy;
  logic [2*MW-1:0]      plox;
  logic [2*MW-1:0]      phix;
  logic [2*MW-1:0]      ploy;
  logic [2*MW-1:0]      phiy;

  always_comb begin
    rx_in = cc_cord[ROTATE_STAGES].x;
    ry_in = cc_cord[ROTATE_STAGES].y;
    magx  = rx_in[CW-1] ? -rx_in : rx_in;
    magy  = ry_in[CW-1] ? -ry_in : ry_in;
    plox  = magx[MW-1:0] * GAIN_INV_Q30;
    phix  = magx[CW-1:MW] * GAIN_INV_Q30;
    ploy  = magy[MW-1:0] * GAIN_INV_Q30;
    phiy  = magy[CW-1:MW] * GAIN_INV_Q30;
  end

  ctl_t                 g2_ctl_r;
  logic signed [CW-1:0] g2_x_r;
  logic signed [CW-1:0] g2_y_r;
  logic [2*MW:0]        rndx;
  logic [2*MW:0]        rndy;
  logic [CW-1:0]        gx;
  logic [CW-1:0]        gy;
  logic signed [CW-1:0] g2_x_nxt;
  logic signed [CW-1:0] g2_y_nxt;

  always_comb begin
    rndx = {1'b0, g1_plox_r} + RND_HALF;
    rndy = {1'b0, g1_ploy_r} + RND_HALF;
    gx   = g1_phix_r + CW'(rndx[2*MW:MW]);
    gy   = g1_phiy_r + CW'(rndy[2*MW:MW]);
    if (rotate_r) begin
      g2_x_nxt = g1_negx_r ? -$signed(gx) : $signed(gx);
      g2_y_nxt = g1_negy_r ? -$signed(gy) : $signed(gy);
    end else begin
      g2_x_nxt = g1_x_r;
      g2_y_nxt = g1_y_r;
    end
  end

  // divider setup: magnitudes, rounding offsets, world-side rounding
  ctl_t                 d0_ctl_r;
  logic [CW-1:0]        d0_mag_a_r;
  logic [CW-1:0]        d0_mag_b_r;
  logic                 d0_neg_a_r;
  logic                 d0_neg_b_r;
  logic signed [CW-1:0] va;
  logic signed [CW-1:0] vb;

  always_comb begin
    if (g2_ctl_r.op == OP_TO_WORLD) begin
      va = g2_x_r;
      vb = g2_y_r;
    end else begin
      va = g2_y_r;
      vb = g2_x_r;
    end
  end

  ctl_t                 d1_ctl_r;
  div_lane_t            d1_lane_a_r;
  div_lane_t            d1_lane_b_r;
  logic signed [RW-1:0] d1_rs_a_r;
  logic signed [RW-1:0] d1_rs_b_r;
  logic [CW:0]          na;
  logic [CW:0]          nbd;
  logic [CW:0]          sa;
  logic [CW:0]          sb;
  logic [CW-8:0]        r8a;
  logic [CW-8:0]        r8b;
  logic [31:0]          hia;
  logic [31:0]          hib;

  always_comb begin
    na  = {1'b0, d0_mag_a_r} + (CW+1)'(view_extent_r[31:1]);
    nbd = {1'b0, d0_mag_b_r} + (CW+1)'(view_extent_r[31:1]);
    hia = 32'(na[CW:32]);
    hib = 32'(nbd[CW:32]);
    sa  = {1'b0, d0_mag_a_r} + (CW+1)'(128);
    sb  = {1'b0, d0_mag_b_r} + (CW+1)'(128);
    r8a = sa[CW:8];
    r8b = sb[CW:8];
  end

  function automatic logic [32:0] sat32(input logic signed [SW-1:0] v);
    logic clip;
    clip = !((&v[SW-1:31]) || !(|v[SW-1:31]));
    if (clip) begin
      return {1'b1, v[SW-1] ? 32'h8000_0000 : 32'h7FFF_FFFF};
    end
    return {1'b0, v[31:0]};
  endfunction

  ctl_t        d2_ctl_r;
  div_lane_t   d2_lane_a_r;
  div_lane_t   d2_lane_b_r;
  logic [32:0] sat_a;
  logic [32:0] sat_b;
  div_lane_t   d2_lane_a_nxt;
  div_lane_t   d2_lane_b_nxt;

  always_comb begin
    sat_a         = sat32(SW'(origin_x_r) + SW'(d1_rs_a_r));
    sat_b         = sat32(SW'(origin_y_r) + SW'(d1_rs_b_r));
    d2_lane_a_nxt = d1_lane_a_r;
    d2_lane_b_nxt = d1_lane_b_r;
    if (d1_ctl_r.op == OP_TO_WORLD) begin
      // world-side result rides the divider chain untouched
      d2_lane_a_nxt = '{rem: '0, num: '0, q: sat_a[31:0], neg: 1'b0, ovf: sat_a[32]};
      d2_lane_b_nxt = '{rem: '0, num: '0, q: sat_b[31:0], neg: 1'b0, ovf: sat_b[32]};
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      g1_ctl_r <= '0;
      g2_ctl_r <= '0;
      d0_ctl_r <= '0;
      d1_ctl_r <= '0;
      d2_ctl_r <= '0;
    end else begin
      g1_ctl_r        <= cc_ctl[ROTATE_STAGES];
      g2_ctl_r        <= g1_ctl_r;
      d0_ctl_r        <= g2_ctl_r;
      d1_ctl_r.vld    <= d0_ctl_r.vld;
      d1_ctl_r.op     <= d0_ctl_r.op;
      d1_ctl_r.div_en <= (d0_ctl_r.op == OP_TO_FRAME) && (view_extent_r != '0);
      d2_ctl_r        <= d1_ctl_r;
    end
  end

  always_ff @(posedge clk) begin
    g1_negx_r   <= rx_in[CW-1];
    g1_negy_r   <= ry_in[CW-1];
    g1_plox_r   <= plox;
    g1_phix_r   <= phix;
    g1_ploy_r   <= ploy;
    g1_phiy_r   <= phiy;
    g1_x_r      <= rx_in;
    g1_y_r      <= ry_in;
    g2_x_r      <= g2_x_nxt;
    g2_y_r      <= g2_y_nxt;
    d0_mag_a_r  <= va[CW-1] ? -va : va;
    d0_mag_b_r  <= vb[CW-1] ? -vb : vb;
    d0_neg_a_r  <= va[CW-1];
    // frame y comes from minus dx, so its sign is that of -dx
    d0_neg_b_r  <= (g2_ctl_r.op == OP_TO_WORLD) ? vb[CW-1] : (!vb[CW-1] && (vb != '0));
    d1_lane_a_r <= '{rem: hia, num: na[31:0], q: '0, neg: d0_neg_a_r,
                     ovf: (hia >= view_extent_r)};
    d1_lane_b_r <= '{rem: hib, num: nbd[31:0], q: '0, neg: d0_neg_b_r,
                     ovf: (hib >= view_extent_r)};
    d1_rs_a_r   <= d0_neg_a_r ? -$signed({1'b0, r8a}) : $signed({1'b0, r8a});
    d1_rs_b_r   <= d0_neg_b_r ? -$signed({1'b0, r8b}) : $signed({1'b0, r8b});
    d2_lane_a_r <= d2_lane_a_nxt;
    d2_lane_b_r <= d2_lane_b_nxt;
  end

  // divider cell chain
  ctl_t      dv_ctl    [DIV_STEPS+1];
  div_lane_t dv_lane_a [DIV_STEPS+1];
  div_lane_t dv_lane_b [DIV_STEPS+1];

  assign dv_ctl[0]    = d2_ctl_r;
  assign dv_lane_a[0] = d2_lane_a_r;
  assign dv_lane_b[0] = d2_lane_b_r;

  for (genvar j = 0; j < DIV_STEPS; j++) begin : g_div
    vprs_div_cell u_cell (
      .clk       (clk),
      .rst_n     (rst_n),
      .divisor   (view_extent_r),
      .ctl_in    (dv_ctl[j]),
      .lane_a_in (dv_lane_a[j]),
      .lane_b_in (dv_lane_b[j]),
      .ctl_out   (dv_ctl[j+1]),
      .lane_a_out(dv_lane_a[j+1]),
      .lane_b_out(dv_lane_b[j+1])
    );
  end

  // final sign and saturation
  function automatic logic [32:0] fin_lane(input logic op, input logic div_en,
                                           input div_lane_t l);
    logic clip;
    if (op == OP_TO_WORLD) begin
      return {l.ovf, l.q};
    end
    if (!div_en) begin
      return '0;
    end
    if (l.ovf) begin
      return {1'b1, l.neg ? 32'h8000_0000 : 32'h7FFF_FFFF};
    end
    if (l.neg) begin
      clip = l.q > 32'h8000_0000;
      return {clip, clip ? 32'h8000_0000 : (32'd0 - l.q)};
    end
    clip = l.q[31];
    return {clip, clip ? 32'h7FFF_FFFF : l.q};
  endfunction

  logic        out_strobe_r;
  out_item_t   out_data_r;
  logic        out_op_r;
  logic [32:0] fin_a;
  logic [32:0] fin_b;

  assign fin_a = fin_lane(dv_ctl[DIV_STEPS].op, dv_ctl[DIV_STEPS].div_en,
                          dv_lane_a[DIV_STEPS]);
  assign fin_b = fin_lane(dv_ctl[DIV_STEPS].op, dv_ctl[DIV_STEPS].div_en,
                          dv_lane_b[DIV_STEPS]);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_strobe_r <= 1'b0;
    end else begin
      out_strobe_r <= dv_ctl[DIV_STEPS].vld;
    end
  end

  always_ff @(posedge clk) begin
    out_data_r.out_a   <= fin_a[31:0];
    out_data_r.out_b   <= fin_b[31:0];
    out_data_r.clipped <= fin_a[32] | fin_b[32];
    out_op_r           <= dv_ctl[DIV_STEPS].op;
  end

  assign out_strobe = out_strobe_r;
  assign out_data   = out_data_r;

  `VPRS_ASSERT_DELAY(a_latency, in_acc, LAT, out_strobe)
  `VPRS_ASSERT_IMP(a_zero_extent, out_strobe && (out_op_r == OP_TO_FRAME) && (view_extent_r == '0), out_data == '0)
  `VPRS_ASSERT_NEXT(a_ovf_clips, dv_ctl[DIV_STEPS].vld && dv_ctl[DIV_STEPS].div_en && dv_lane_a[DIV_STEPS].ovf, out_data.clipped)

endmodule

// ===== rtl/vprs_cordic_cell.sv =====
// one rotation cell of the cordic chain
module vprs_cordic_cell import vprs_pkg::*; (
  input  logic       clk,
  input  logic       rst_n,
  input  logic [4:0] stage_idx,
  input  logic       rot_en,
  input  ctl_t       ctl_in,
  input  cord_t      cord_in,
  output ctl_t       ctl_out,
  output cord_t      cord_out
);

  ctl_t                 ctl_r;
  cord_t                cord_r;
  cord_t                cord_nxt;
  logic signed [CW-1:0] sx;
  logic signed [CW-1:0] sy;
  logic signed [ZW-1:0] atan_z;

  always_comb begin
    sx       = $signed(cord_in.y) >>> stage_idx;
    sy       = $signed(cord_in.x) >>> stage_idx;
    atan_z   = {{(ZW-32){1'b0}}, ATAN_TAB[stage_idx]};
    cord_nxt = cord_in;
    if (rot_en) begin
      if (!cord_in.z[ZW-1]) begin
        cord_nxt.x = $signed(cord_in.x) - sx;
        cord_nxt.y = $signed(cord_in.y) + sy;
        cord_nxt.z = $signed(cord_in.z) - atan_z;
      end else begin
        cord_nxt.x = $signed(cord_in.x) + sx;
        cord_nxt.y = $signed(cord_in.y) - sy;
        cord_nxt.z = $signed(cord_in.z) + atan_z;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ctl_r <= '0;
    end else begin
      ctl_r <= ctl_in;
    end
  end

  always_ff @(posedge clk) begin
    cord_r <= cord_nxt;
  end

  assign ctl_out  = ctl_r;
  assign cord_out = cord_r;

endmodule

// ===== rtl/vprs_div_cell.sv =====
// one restoring division cell, one quotient bit per lane
module vprs_div_cell import vprs_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  logic [31:0] divisor,
  input  ctl_t        ctl_in,
  input  div_lane_t   lane_a_in,
  input  div_lane_t   lane_b_in,
  output ctl_t        ctl_out,
  output div_lane_t   lane_a_out,
  output div_lane_t   lane_b_out
);

  ctl_t      ctl_r;
  div_lane_t lane_a_r;
  div_lane_t lane_b_r;

  function automatic div_lane_t div_step(input div_lane_t l, input logic [31:0] d,
                                         input logic en);
    div_lane_t   o;
    logic [32:0] trial;
    logic [32:0] diff;
    o     = l;
    trial = {l.rem, l.num[31]};
    diff  = trial - {1'b0, d};
    if (en) begin
      o.num = {l.num[30:0], 1'b0};
      if (trial >= {1'b0, d}) begin
        o.rem = diff[31:0];
        o.q   = {l.q[30:0], 1'b1};
      end else begin
        o.rem = trial[31:0];
        o.q   = {l.q[30:0], 1'b0};
      end
    end
    return o;
  endfunction

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ctl_r <= '0;
    end else begin
      ctl_r <= ctl_in;
    end
  end

  always_ff @(posedge clk) begin
    lane_a_r <= div_step(lane_a_in, divisor, ctl_in.div_en);
    lane_b_r <= div_step(lane_b_in, divisor, ctl_in.div_en);
  end

  assign ctl_out    = ctl_r;
  assign lane_a_out = lane_a_r;
  assign lane_b_out = lane_b_r;

endmodule

// ===== tb/view_projection_rotate_scale_tb.sv =====
// testbench of the world/frame coordinate transform: predicted results checked per transfer
`timescale 1ns / 1ps
module view_projection_rotate_scale_tb;
  import vprs_pkg::*;

  localparam int LATENCY     = ROTATE_STAGES + 41;
  localparam int STALL_LIMIT = 4000;

  logic                 clk;
  logic                 rst_n;
  logic                 start;
  logic                 busy;
  in_item_t             in_data;
  logic                 out_strobe;
  out_item_t            out_data;
  logic                 cfg_we;
  logic [CFG_IDX_W-1:0] cfg_idx;
  logic [31:0]          cfg_wdata;

  view_projection_rotate_scale u_top (
    .clk        (clk),
    .rst_n      (rst_n),
    .start      (start),
    .busy       (busy),
    .in_data    (in_data),
    .out_strobe (out_strobe),
    .out_data   (out_data),
    .cfg_we     (cfg_we),
    .cfg_idx    (cfg_idx),
    .cfg_wdata  (cfg_wdata)
  );

  always begin
    clk = 1'b1;
    #6;
    clk = 1'b0;
    #6;
  end

  // register shadow used by the predictor
  logic [31:0] org_x, org_y, extent;
  logic [15:0] yaw;
  logic        rot_en;

  out_item_t expected_points[$];
  int        mismatches;
  int        quiet_cycles;
  int        send_idle_pct;

  function automatic longint gain_fix(longint v);
    longint unsigned m, h, l, r;
    m = (v < 0) ? longint'(-v) : v;
    h = m >> 32;
    l = m & 64'hFFFF_FFFF;
    r = h * 64'h26DD3B6A * 4 + ((l * 64'h26DD3B6A + 64'd536870912) >> 30);
    return (v < 0) ? -longint'(r) : longint'(r);
  endfunction

  function automatic void cordic_rotate(inout longint x, inout longint y,
                                        input logic [31:0] ang);
    longint sx, sy, z;
    if (ang[31:30] == 2'd1 || ang[31:30] == 2'd2) begin
      x = -x;
      y = -y;
      ang = ang + 32'h8000_0000;
    end
    z = longint'($signed(ang));
    for (int i = 0; i < ROTATE_STAGES; i++) begin
      sx = y >>> i;
      sy = x >>> i;
      if (z >= 0) begin
        x = x - sx; y = y + sy; z = z - longint'(ATAN_TAB[i]);
      end else begin
        x = x + sx; y = y - sy; z = z + longint'(ATAN_TAB[i]);
      end
    end
    x = gain_fix(x);
    y = gain_fix(y);
  endfunction

  function automatic longint div_round(longint n, longint unsigned d);
    longint unsigned m;
    m = (n < 0) ? longint'(-n) : n;
    m = (m + d / 2) / d;
    return (n < 0) ? -longint'(m) : longint'(m);
  endfunction

  function automatic longint round_q8(longint v);
    longint unsigned m;
    m = (v < 0) ? longint'(-v) : v;
    m = (m + 128) >> 8;
    return (v < 0) ? -longint'(m) : longint'(m);
  endfunction

  function automatic logic [31:0] clamp32(longint v, inout logic clip);
    if (v > 64'sh7FFF_FFFF) begin
      v = 64'sh7FFF_FFFF; clip = 1'b1;
    end
    if (v < -64'sh8000_0000) begin
      v = -64'sh8000_0000; clip = 1'b1;
    end
    return v[31:0];
  endfunction

  function automatic out_item_t project_point(in_item_t it);
    out_item_t r;
    longint a, b, ox, oy, e, dx, dy, ra, rb;
    logic clip;
    a  = longint'(it.coord_a);
    b  = longint'(it.coord_b);
    ox = longint'($signed(org_x));
    oy = longint'($signed(org_y));
    e  = longint'({32'd0, extent});
    clip = 1'b0;
    if (it.op == OP_TO_FRAME) begin
      if (extent == 32'd0) return '0;
      dx = (a - ox) * 65536;
      dy = (b - oy) * 65536;
      if (rot_en) cordic_rotate(dx, dy, {16'(17'h10000 - yaw), 16'd0});
      ra = div_round(dy, e);
      rb = div_round(-dx, e);
    end else begin
      dx = (-(b * e)) >>> 8;
      dy = (a * e) >>> 8;
      if (rot_en) cordic_rotate(dx, dy, {yaw, 16'd0});
      ra = ox + round_q8(dx);
      rb = oy + round_q8(dy);
    end
    r.out_a   = clamp32(ra, clip);
    r.out_b   = clamp32(rb, clip);
    r.clipped = clip;
    return r;
  endfunction

  // result checker and stall watchdog
  always @(posedge clk) begin
    if (rst_n) begin
      if ((start && !busy) || out_strobe) begin
        quiet_cycles <= 0;
      end else begin
        quiet_cycles <= quiet_cycles + 1;
      end
      if (out_strobe) begin
        if (expected_points.size() == 0) begin
          mismatches <= mismatches + 1;
          if (mismatches < 10) $display("unexpected result transfer: %p", out_data);
        end else begin
          out_item_t want;
          want = expected_points.pop_front();
          if (out_data.out_a !== want.out_a || out_data.out_b !== want.out_b ||
              out_data.clipped !== want.clipped) begin
            mismatches <= mismatches + 1;
            if (mismatches < 10)
              $display("mismatch: expected a=%0d b=%0d clip=%0b, got a=%0d b=%0d clip=%0b",
                       want.out_a, want.out_b, want.clipped,
                       out_data.out_a, out_data.out_b, out_data.clipped);
          end
        end
      end
      if (quiet_cycles > STALL_LIMIT) begin
        $display("Testbench completed WITH ERRORS");
        $finish;
      end
    end
  end

  task automatic send_point(logic op, logic [31:0] ca, logic [31:0] cb);
    in_item_t it;
    it.op = op;
    it.coord_a = ca;
    it.coord_b = cb;
    start   <= 1'b1;
    in_data <= it;
    @(negedge clk);
    while (busy) @(negedge clk);
    @(posedge clk);
    expected_points.push_back(project_point(it));
    if ($urandom_range(99) < send_idle_pct) begin
      start <= 1'b0;
      repeat ($urandom_range(1, 4)) @(posedge clk);
    end
  endtask

  task automatic drain();
    start <= 1'b0;
    @(posedge clk);
    while (expected_points.size() != 0) @(posedge clk);
  endtask

  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [31:0] val);
    drain();
    cfg_we    <= 1'b1;
    cfg_idx   <= idx;
    cfg_wdata <= val;
    @(posedge clk);
    cfg_we <= 1'b0;
    case (idx)
      CFG_ORIGIN_X:    org_x  = val;
      CFG_ORIGIN_Y:    org_y  = val;
      CFG_VIEW_YAW:    yaw    = val[15:0];
      CFG_VIEW_EXTENT: extent = val;
      CFG_ROTATE:      rot_en = val[0];
      default: ;
    endcase
  endtask

  function automatic logic [31:0] pick_coord(logic [31:0] org);
    case ($urandom_range(5))
      0, 1: return $urandom();
      2:    return org + 32'($signed(17'($urandom())));
      3:    return 32'($signed(13'($urandom())));
      4:    return org + 32'($signed(25'($urandom())));
      default: begin
        case ($urandom_range(3))
          0: return 32'h7FFF_FFFF;
          1: return 32'h8000_0000;
          2: return 32'hFFFF_FFFF;
          default: return 32'd0;
        endcase
      end
    endcase
  endfunction

  function automatic logic [31:0] pick_extent();
    case ($urandom_range(6))
      0: return 32'd0;
      1: return 32'hFFFF_FFFF;
      2: return 32'd1;
      3: return $urandom();
      default: return $urandom_range(1, 65536);
    endcase
  endfunction

  task automatic test_directed();
    logic [15:0] yaws[6];
    yaws = '{16'h0000, 16'h4000, 16'h8000, 16'hC000, 16'hFFFF, 16'h2000};
    send_point(OP_TO_FRAME, 32'd0, 32'd0);
    send_point(OP_TO_FRAME, 32'h7FFF_FFFF, 32'h8000_0000);
    send_point(OP_TO_WORLD, 32'h8000_0000, 32'h7FFF_FFFF);
    send_point(OP_TO_WORLD, 32'h0001_0000, 32'hFFFF_0000);
    write_reg(CFG_ORIGIN_X, 32'h8000_0000);
    write_reg(CFG_ORIGIN_Y, 32'h7FFF_FFFF);
    // origin at the extremes drives both deltas and sums out of range
    send_point(OP_TO_FRAME, 32'h7FFF_FFFF, 32'h8000_0000);
    send_point(OP_TO_WORLD, 32'h7FFF_FFFF, 32'h8000_0000);
    write_reg(CFG_VIEW_EXTENT, 32'd0);
    // zero extent: forward gives zeros, inverse returns the origin
    send_point(OP_TO_FRAME, 32'h1234_5678, 32'h8765_4321);
    send_point(OP_TO_WORLD, 32'h1234_5678, 32'h8765_4321);
    write_reg(CFG_VIEW_EXTENT, 32'hFFFF_FFFF);
    write_reg(CFG_ORIGIN_X, 32'd0);
    write_reg(CFG_ORIGIN_Y, 32'd0);
    send_point(OP_TO_WORLD, 32'h8000_0000, 32'h8000_0000);
    send_point(OP_TO_FRAME, 32'h0000_0180, 32'hFFFF_FE80);
    write_reg(CFG_VIEW_EXTENT, 32'd256);
    write_reg(CFG_ROTATE, 32'hFFFF_FFFF);
    // one frame and one world point per yaw: the quadrant boundaries, just below zero and 45 degrees
    foreach (yaws[i]) begin
      write_reg(CFG_VIEW_YAW, {16'hA5A5, yaws[i]});
      send_point(OP_TO_FRAME, 32'h0001_0000, 32'hFFFF_8000);
      send_point(OP_TO_WORLD, 32'h0003_0000, 32'h0000_4000);
    end
    write_reg(3'd5, $urandom());
    write_reg(3'd7, $urandom());
    send_point(OP_TO_FRAME, 32'h0000_0100, 32'h0000_0200);
    drain();
  endtask

  task automatic test_random(int sender_pct, int phases);
    send_idle_pct = sender_pct;
    for (int p = 0; p < phases; p++) begin
      write_reg(CFG_ORIGIN_X, ($urandom_range(3) == 0) ? $urandom() :
                32'($signed(20'($urandom()))));
      write_reg(CFG_ORIGIN_Y, ($urandom_range(3) == 0) ? $urandom() :
                32'($signed(20'($urandom()))));
      write_reg(CFG_VIEW_YAW, $urandom());
      write_reg(CFG_VIEW_EXTENT, pick_extent());
      write_reg(CFG_ROTATE, $urandom());
      if ($urandom_range(4) == 0) write_reg(3'($urandom_range(5, 7)), $urandom());
      for (int n = 0; n < 40; n++) begin
        send_point(1'($urandom()), pick_coord(org_x), pick_coord(org_y));
        // let the pipeline empty completely once in a while
        if ($urandom_range(49) == 0) drain();
      end
    end
    drain();
  endtask

  initial begin
    rst_n        = 1'b0;
    start        = 1'b0;
    in_data      = '0;
    cfg_we       = 1'b0;
    cfg_idx      = '0;
    cfg_wdata    = '0;
    mismatches   = 0;
    quiet_cycles = 0;
    send_idle_pct = 0;
    org_x  = 32'd0;
    org_y  = 32'd0;
    yaw    = 16'd0;
    extent = 32'd256;
    rot_en = 1'b0;
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_directed();
    test_random(25, 5);
    test_random(64, 5);
    test_random(0, 5);
    drain();
    repeat (LATENCY + 10) @(posedge clk);
    if (mismatches == 0 && expected_points.size() == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule
